// ----- rtl/fpvm_pkg.sv -----
// Shared constants, state encoding and control bundle for the vector magnitude unit.
// Depends on nothing; every other file refers to it by scoped names.
package fpvm_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int IN_W          = 32;
   localparam int PROD_W        = 2 * IN_W;
   localparam int ROOT_W        = PROD_W / 2;
   localparam int REM_W         = ROOT_W + 2;
   localparam int TRIAL_W       = REM_W + 2;
   localparam int ROOT_STEPS    = ROOT_W;
   localparam int CNT_W         = $clog2(ROOT_STEPS);

   // Clears the fraction bits that the radicand drops.
   localparam logic [PROD_W-1:0] FRAC_MASK =
      {{(PROD_W - FRACTION_BITS){1'b1}}, {FRACTION_BITS{1'b0}}};

   // Largest root possible, from two components of -2^31.
   localparam logic [ROOT_W-1:0] MAG_MAX = ROOT_W'(64'd3037000499);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE_A,
      ST_SQUARE_B,
      ST_LOAD,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic capture;
      logic square_en;
      logic sel_second;
      logic load_sum;
      logic load_root;
      logic step_root;
      logic load_out;
   } ctrl_type;

endpackage

// ----- rtl/fixed_point_vector_magnitude_unit.sv -----
// Top level of the fixed-point vector magnitude unit.
// Depends on fpvm_pkg, fpvm_squarer, fpvm_root and fpvm_seq.
//
// This unit takes two signed 16.16 components per request beat and returns one
// unsigned 16.16 magnitude per response beat: the floor square root of the sum
// of both squares after the low 16 of the sum's 32 fraction bits are cleared,
// so zero gives zero and two components of -2^31 give 3037000499. The block
// works on one beat at a time and holds req_stall high while it does. After
// acceptance a beat passes through the one shared 32 by 32 squarer (first
// component, then second), an add and mask of the squares, the digit-by-digit
// root unit, which settles one result bit per cycle with a single 36-bit
// compare and subtract, a hand-off of the root to the response register and an
// idle state in which the next beat is taken. The response sits in its own
// output register, so a new request is accepted while an earlier response
// still waits behind rsp_stall; only when a second result is ready and that
// register is still full does the block hold its finished root until the
// register frees up.
module fixed_point_vector_magnitude_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [fpvm_pkg::IN_W-1:0]   req_first_component,
   input  logic signed [fpvm_pkg::IN_W-1:0]   req_second_component,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fpvm_pkg::ROOT_W-1:0]        rsp_magnitude
);

   fpvm_pkg::ctrl_type            ctrl;
   fpvm_pkg::state_type           state;
   logic                          out_free;

   logic [fpvm_pkg::IN_W-1:0]     first_ff;
   logic [fpvm_pkg::IN_W-1:0]     second_ff;
   logic [fpvm_pkg::IN_W-1:0]     operand;
   logic [fpvm_pkg::PROD_W-1:0]   product;
   logic [fpvm_pkg::PROD_W-1:0]   sum_ff;
   logic [fpvm_pkg::PROD_W-1:0]   radicand;
   logic [fpvm_pkg::ROOT_W-1:0]   root;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [fpvm_pkg::ROOT_W-1:0]   rsp_magnitude_ff;

   // The response register is free when it is empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = ctrl.busy;

   fpvm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .state     (state)
   );

   // Operands are captured on acceptance and stay put for the whole computation.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         first_ff  <= req_first_component;
         second_ff <= req_second_component;
      end
   end

   assign operand = ctrl.sel_second ? second_ff : first_ff;

   fpvm_squarer u_squarer (
      .clock   (clock),
      .enable  (ctrl.square_en),
      .operand (operand),
      .product (product)
   );

   // The first square is parked here while the squarer works on the second.
   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         sum_ff <= product;
      end
   end

   // Both squares are at most 2^62, so their sum never carries out of 64 bits.
   assign radicand = (sum_ff + product) & fpvm_pkg::FRAC_MASK;

   fpvm_root u_root (
      .clock    (clock),
      .load     (ctrl.load_root),
      .step     (ctrl.step_root),
      .radicand (radicand),
      .root     (root)
   );

   assign rsp_valid_in = ctrl.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         rsp_magnitude_ff <= root;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_magnitude_ff;

`ifndef SYNTHESIS
   // An accepted beat must put the block into its busy sequence.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state == fpvm_pkg::ST_SQUARE_A))
      else $error("accepted beat did not start the squaring sequence");

   // A new response appears only after the root iterations have finished.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.load_out |-> (state == fpvm_pkg::ST_FINISH) && $past(state == fpvm_pkg::ST_ROOT ||
                                                                state == fpvm_pkg::ST_FINISH))
      else $error("response loaded before the root was complete");

   // No pair of 16.16 components can produce a root above the largest possible one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_magnitude <= fpvm_pkg::MAG_MAX))
      else $error("magnitude exceeds the largest possible root");

   // A pending response is never overwritten by the next result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !ctrl.load_out)
      else $error("pending response overwritten");
`endif

endmodule

// ----- rtl/fpvm_squarer.sv -----
// Shared squaring unit: absolute value of a signed component and a registered square.
// Depends on fpvm_pkg.
module fpvm_squarer (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [fpvm_pkg::IN_W-1:0]     operand,
   output logic [fpvm_pkg::PROD_W-1:0]   product
);

   logic [fpvm_pkg::IN_W-1:0]   mag;
   logic [fpvm_pkg::PROD_W-1:0] product_in;
   logic [fpvm_pkg::PROD_W-1:0] product_ff;

   // The most negative value maps to 2^(IN_W-1), which still fits unsigned.
   assign mag        = operand[fpvm_pkg::IN_W-1] ? (~operand + 1'b1) : operand;
   assign product_in = fpvm_pkg::PROD_W'(mag) * fpvm_pkg::PROD_W'(mag);

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ----- rtl/fpvm_root.sv -----
// Digit-by-digit floor square root, one result bit per step.
// Depends on fpvm_pkg.
module fpvm_root (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  logic [fpvm_pkg::PROD_W-1:0]   radicand,
   output logic [fpvm_pkg::ROOT_W-1:0]   root
);

   logic [fpvm_pkg::PROD_W-1:0]  rad_ff;
   logic [fpvm_pkg::PROD_W-1:0]  rad_in;
   logic [fpvm_pkg::REM_W-1:0]   rem_ff;
   logic [fpvm_pkg::REM_W-1:0]   rem_in;
   logic [fpvm_pkg::ROOT_W-1:0]  root_ff;
   logic [fpvm_pkg::ROOT_W-1:0]  root_in;
   logic [fpvm_pkg::TRIAL_W-1:0] shifted;
   logic [fpvm_pkg::TRIAL_W-1:0] trial;
   logic [fpvm_pkg::TRIAL_W-1:0] diff;
   logic                         fits;

   // Bring down the next two radicand bits and try appending a one to the root.
   assign shifted = {rem_ff, rad_ff[fpvm_pkg::PROD_W-1 -: 2]};
   assign trial   = fpvm_pkg::TRIAL_W'({root_ff, 2'b01});
   assign fits    = (shifted >= trial);
   assign diff    = shifted - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (step) begin
         rad_in  = {rad_ff[fpvm_pkg::PROD_W-3:0], 2'b00};
         rem_in  = fits ? diff[fpvm_pkg::REM_W-1:0] : shifted[fpvm_pkg::REM_W-1:0];
         root_in = {root_ff[fpvm_pkg::ROOT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

// ----- rtl/fpvm_seq.sv -----
// Sequencer: walks one beat through squaring, summing, the root iterations and the hand-off.
// Depends on fpvm_pkg.
module fpvm_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               out_free,
   output fpvm_pkg::ctrl_type ctrl,
   output fpvm_pkg::state_type state
);

   fpvm_pkg::state_type          state_ff;
   fpvm_pkg::state_type          state_in;
   logic [fpvm_pkg::CNT_W-1:0]   cnt_ff;
   logic [fpvm_pkg::CNT_W-1:0]   cnt_in;
   logic                         last_step;

   assign last_step = (cnt_ff == fpvm_pkg::CNT_W'(fpvm_pkg::ROOT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpvm_pkg::ST_IDLE: begin
            if (req_valid) state_in = fpvm_pkg::ST_SQUARE_A;
         end
         fpvm_pkg::ST_SQUARE_A: state_in = fpvm_pkg::ST_SQUARE_B;
         fpvm_pkg::ST_SQUARE_B: state_in = fpvm_pkg::ST_LOAD;
         fpvm_pkg::ST_LOAD:     state_in = fpvm_pkg::ST_ROOT;
         fpvm_pkg::ST_ROOT: begin
            if (last_step) state_in = fpvm_pkg::ST_FINISH;
         end
         fpvm_pkg::ST_FINISH: begin
            if (out_free) state_in = fpvm_pkg::ST_IDLE;
         end
         default: state_in = fpvm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         fpvm_pkg::ST_IDLE: begin
            ctrl.capture = req_valid;
         end
         fpvm_pkg::ST_SQUARE_A: begin
            ctrl.busy      = 1'b1;
            ctrl.square_en = 1'b1;
         end
         fpvm_pkg::ST_SQUARE_B: begin
            ctrl.busy       = 1'b1;
            ctrl.square_en  = 1'b1;
            ctrl.sel_second = 1'b1;
            ctrl.load_sum   = 1'b1;
         end
         fpvm_pkg::ST_LOAD: begin
            ctrl.busy      = 1'b1;
            ctrl.load_root = 1'b1;
         end
         fpvm_pkg::ST_ROOT: begin
            ctrl.busy      = 1'b1;
            ctrl.step_root = 1'b1;
         end
         fpvm_pkg::ST_FINISH: begin
            ctrl.busy     = 1'b1;
            ctrl.load_out = out_free;
         end
         default: ctrl = '0;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == fpvm_pkg::ST_LOAD) begin
         cnt_in = '0;
      end else if (state_ff == fpvm_pkg::ST_ROOT) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpvm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign state = state_ff;

endmodule
